@@ hw/rtl/lcc_pkg.sv @@
// Shared constants, types and the weight function of the calibrated line sensor centroid block.
`timescale 1ns / 1ps
package lcc_pkg;
    localparam int NUM_SENSORS  = 8;
    localparam int READING_BITS = 16;
    localparam int WEIGHT_STEP  = 1000;

    localparam int FRAC_SHIFT = 16;
    localparam int FRAC_W     = FRAC_SHIFT + 1;
    localparam int IDX_W      = $clog2(NUM_SENSORS);
    localparam int W_MAX      = NUM_SENSORS * WEIGHT_STEP * 16;
    localparam int W_MIN      = WEIGHT_STEP * 16;
    localparam int Q_BITS     = $clog2(W_MAX + 1);
    localparam int DEN_W      = FRAC_W + $clog2(NUM_SENSORS);
    localparam int NUM_W      = FRAC_W + Q_BITS + $clog2(NUM_SENSORS);
    localparam int CNT_W      = $clog2(Q_BITS + FRAC_SHIFT + 1);
    localparam int POS_W      = 17;
    localparam int POS_MAX    = 131071;
    localparam int SAT_W      = (Q_BITS > POS_W) ? Q_BITS : POS_W;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CAL    = 2'd1,
        ST_NOTCAL = 2'd2,
        ST_NOLINE = 2'd3
    } t_status;

    typedef enum logic {
        CMD_CALIBRATE = 1'b0,
        CMD_POSITION  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV0,
        S_DIV,
        S_ACC,
        S_CHK,
        S_FIN,
        S_OUT
    } t_back_state;

    typedef logic [NUM_SENSORS-1:0][READING_BITS-1:0] t_readings;

    typedef struct packed {
        t_status   status;
        t_readings off;
        t_readings span;
    } t_job;

    function automatic logic [Q_BITS-1:0] weight(input logic [IDX_W-1:0] idx);
        int w;
        begin
            w = (int'(idx) + 1) * WEIGHT_STEP * 16;
            weight = Q_BITS'(w);
        end
    endfunction
endpackage

@@ hw/rtl/lcc_front.sv @@
// Front end: keeps calibration ranges, classifies each word and builds the job.
`timescale 1ns / 1ps
module lcc_front import lcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic      i_command,
    input  t_readings i_decay,
    output t_job      o_job
);
    logic [NUM_SENSORS-1:0][READING_BITS-1:0] r_high, r_low;
    logic [NUM_SENSORS-1:0][READING_BITS-1:0] n_high, n_low;
    logic      notcal;
    t_readings off, span;
    logic [READING_BITS-1:0] rc;

    always_comb begin
        n_high = r_high;
        n_low  = r_low;
        notcal = 1'b0;
        rc     = '0;
        off    = '0;
        span   = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (i_decay[i] > r_high[i]) n_high[i] = i_decay[i];
            if (i_decay[i] < r_low[i])  n_low[i]  = i_decay[i];
            if (r_high[i] <= r_low[i]) notcal = 1'b1;
            rc = i_decay[i];
            if (rc > r_high[i]) rc = r_high[i];
            if (rc < r_low[i])  rc = r_low[i];
            off[i]  = rc - r_low[i];
            span[i] = r_high[i] - r_low[i];
        end
        o_job.off  = off;
        o_job.span = span;
        if (t_cmd'(i_command) == CMD_CALIBRATE) begin
            o_job.status = ST_CAL;
        end else if (notcal) begin
            o_job.status = ST_NOTCAL;
        end else begin
            o_job.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_high[i] <= READING_BITS'(1);
                r_low[i]  <= '1;
            end
        end else if (i_accept && t_cmd'(i_command) == CMD_CALIBRATE) begin
            r_high <= n_high;
            r_low  <= n_low;
        end
    end
endmodule

@@ hw/rtl/lcc_fifo.sv @@
// Short job queue between front and back end.
`timescale 1ns / 1ps
module lcc_fifo import lcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    t_job r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == PTR_W'(FIFO_DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == PTR_W'(FIFO_DEPTH-1)) ? '0 : r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

@@ hw/rtl/lcc_back.sv @@
// Back end: per-sensor fraction divide, weighted sums, centroid divide, result register.
`timescale 1ns / 1ps
module lcc_back import lcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_job             i_q_data,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [POS_W-1:0] o_position_q4,
    output t_status          o_status
);
    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [READING_BITS-1:0] r_frem, n_frem;
    logic [FRAC_W-1:0]       r_frac, n_frac;
    logic [NUM_W-1:0]        r_num, n_num;
    logic [DEN_W-1:0]        r_den, n_den;
    logic [DEN_W-1:0]        r_drem, n_drem;
    logic [Q_BITS-1:0]       r_nlo, n_nlo;
    logic [Q_BITS-1:0]       r_quo, n_quo;
    logic [POS_W-1:0]        r_res_pos, n_res_pos;
    t_status                 r_res_st, n_res_st;
    logic                    r_out_v, n_out_v;
    logic [POS_W-1:0]        r_pos, n_pos;
    t_status                 r_st, n_st;

    logic [READING_BITS-1:0] cur_off, cur_span;
    logic [READING_BITS:0]   ft;
    logic [DEN_W:0]          dt;
    logic                    ge;
    logic [2*Q_BITS-1:0]     prod;

    assign o_empty       = !r_out_v;
    assign o_position_q4 = r_pos;
    assign o_status      = r_st;
    assign cur_off       = r_job.off[r_idx];
    assign cur_span      = r_job.span[r_idx];

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_frem    = r_frem;
        n_frac    = r_frac;
        n_num     = r_num;
        n_den     = r_den;
        n_drem    = r_drem;
        n_nlo     = r_nlo;
        n_quo     = r_quo;
        n_res_pos = r_res_pos;
        n_res_st  = r_res_st;
        n_out_v   = r_out_v && !i_pop;
        n_pos     = r_pos;
        n_st      = r_st;
        o_q_pop   = 1'b0;
        ft        = {r_frem, 1'b0};
        dt        = {r_drem, r_nlo[Q_BITS-1]};
        ge        = 1'b0;
        prod      = (2*Q_BITS)'(r_frac) * (2*Q_BITS)'(weight(r_idx));
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    n_job     = i_q_data;
                    n_idx     = '0;
                    n_num     = '0;
                    n_den     = '0;
                    n_res_pos = '0;
                    n_res_st  = i_q_data.status;
                    n_state   = (i_q_data.status == ST_OK) ? S_DIV0 : S_OUT;
                end
            end
            S_DIV0: begin
                ge      = (cur_off >= cur_span);
                n_frem  = ge ? cur_off - cur_span : cur_off;
                n_frac  = FRAC_W'(ge);
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                ge     = (ft >= {1'b0, cur_span});
                n_frem = ge ? READING_BITS'(ft - {1'b0, cur_span}) : READING_BITS'(ft);
                n_frac = {r_frac[FRAC_W-2:0], ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_SHIFT-1)) n_state = S_ACC;
            end
            S_ACC: begin
                n_num = r_num + NUM_W'(prod);
                n_den = r_den + DEN_W'(r_frac);
                if (r_idx == IDX_W'(NUM_SENSORS-1)) begin
                    n_state = S_CHK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DIV0;
                end
            end
            S_CHK: begin
                if (r_den == '0) begin
                    n_res_st = ST_NOLINE;
                    n_state  = S_OUT;
                end else begin
                    n_drem  = DEN_W'(r_num >> Q_BITS);
                    n_nlo   = r_num[Q_BITS-1:0];
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                ge     = (dt >= {1'b0, r_den});
                n_drem = ge ? DEN_W'(dt - {1'b0, r_den}) : DEN_W'(dt);
                n_nlo  = {r_nlo[Q_BITS-2:0], 1'b0};
                n_quo  = {r_quo[Q_BITS-2:0], ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_BITS-1)) begin
                    n_res_pos = (SAT_W'(n_quo) > SAT_W'(POS_MAX)) ?
                                POS_W'(POS_MAX) : POS_W'(n_quo);
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_v || i_pop) begin
                    n_out_v = 1'b1;
                    n_pos   = r_res_pos;
                    n_st    = r_res_st;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_frem    <= n_frem;
        r_frac    <= n_frac;
        r_num     <= n_num;
        r_den     <= n_den;
        r_drem    <= n_drem;
        r_nlo     <= n_nlo;
        r_quo     <= n_quo;
        r_res_pos <= n_res_pos;
        r_res_st  <= n_res_st;
        r_pos     <= n_pos;
        r_st      <= n_st;
    end
endmodule

@@ hw/rtl/line_sensor_calibrated_centroid.sv @@
// Top level of the calibrated line sensor weighted centroid block.
// Flow: calibrate and not-calibrated words go straight from the queue to the result register;
//   position words take one 17-step fraction divide and one accumulate per sensor, then
//   a 17-step centroid divide; no-line words skip the centroid divide.
// The back end works on one word at a time; the two-entry queue takes new words meanwhile.
// Reset: synchronous active low; ranges go to max 1 / min 65535, queue and result empty.
`timescale 1ns / 1ps
module line_sensor_calibrated_centroid import lcc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_command,
    input  logic [READING_BITS-1:0] i_decay_0,
    input  logic [READING_BITS-1:0] i_decay_1,
    input  logic [READING_BITS-1:0] i_decay_2,
    input  logic [READING_BITS-1:0] i_decay_3,
    input  logic [READING_BITS-1:0] i_decay_4,
    input  logic [READING_BITS-1:0] i_decay_5,
    input  logic [READING_BITS-1:0] i_decay_6,
    input  logic [READING_BITS-1:0] i_decay_7,
    output logic                    empty,
    input  logic                    pop,
    output logic [POS_W-1:0]        o_position_q4,
    output logic [1:0]              o_status
);
    t_readings decay;
    t_job      f_job, q_job;
    logic      q_empty, q_pop;
    t_status   st;

    assign decay = {i_decay_7, i_decay_6, i_decay_5, i_decay_4,
                    i_decay_3, i_decay_2, i_decay_1, i_decay_0};
    assign o_status = st;

    lcc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (push && !full),
        .i_command (i_command),
        .i_decay   (decay),
        .o_job     (f_job)
    );

    lcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    lcc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_job),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_position_q4 (o_position_q4),
        .o_status      (st)
    );
endmodule

@@ hw/rtl/lcc_checker.sv @@
// Port-level checker for the line sensor centroid block, bound to the top level.
`timescale 1ns / 1ps
module lcc_checker import lcc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             empty,
    input logic             pop,
    input logic [POS_W-1:0] o_position_q4,
    input logic [1:0]       o_status
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (o_position_q4 == '0))
        else $error("nonzero position with non-ok status");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_OK) |->
        (SAT_W'(o_position_q4) >= SAT_W'(W_MIN) && SAT_W'(o_position_q4) <= SAT_W'(W_MAX)))
        else $error("position outside weight range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_position_q4) && $stable(o_status)))
        else $error("result word changed while waiting");
endmodule

bind line_sensor_calibrated_centroid lcc_checker u_lcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_position_q4 (o_position_q4),
    .o_status      (o_status)
);

@@ tb/testbench.sv @@
// Testbench for the calibrated line sensor centroid block: scoreboard, drivers and checks.
`timescale 1ns / 1ps
module testbench;
    import lcc_pkg::*;

    typedef struct {
        logic [POS_W-1:0] pos;
        t_status          st;
    } t_centroid_word;

    class centroid_scoreboard;
        logic [READING_BITS-1:0] range_hi [NUM_SENSORS];
        logic [READING_BITS-1:0] range_lo [NUM_SENSORS];
        t_centroid_word          pending_words [$];
        int                      mismatches;
        int                      words_in;
        int                      words_out;
        int                      status_seen [4];

        function new();
            for (int i = 0; i < NUM_SENSORS; i++) begin
                range_hi[i] = 1;
                range_lo[i] = '1;
            end
            mismatches = 0;
            words_in   = 0;
            words_out  = 0;
            foreach (status_seen[s]) status_seen[s] = 0;
        endfunction

        function void report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endfunction

        function void note_word(t_cmd cmd, t_readings rd);
            t_centroid_word   w;
            longint unsigned  num;
            longint unsigned  den;
            longint unsigned  frac;
            longint unsigned  q;
            logic [READING_BITS-1:0] r;
            bit               narrow;
            num    = 0;
            den    = 0;
            narrow = 0;
            words_in++;
            w.pos = '0;
            if (cmd == CMD_CALIBRATE) begin
                for (int i = 0; i < NUM_SENSORS; i++) begin
                    if (rd[i] > range_hi[i]) range_hi[i] = rd[i];
                    if (rd[i] < range_lo[i]) range_lo[i] = rd[i];
                end
                w.st = ST_CAL;
            end else begin
                for (int i = 0; i < NUM_SENSORS; i++)
                    if (range_hi[i] <= range_lo[i]) narrow = 1;
                if (narrow) begin
                    w.st = ST_NOTCAL;
                end else begin
                    for (int i = 0; i < NUM_SENSORS; i++) begin
                        r = rd[i];
                        if (r > range_hi[i]) r = range_hi[i];
                        if (r < range_lo[i]) r = range_lo[i];
                        frac = (longint'(r - range_lo[i]) << FRAC_SHIFT)
                               / longint'(range_hi[i] - range_lo[i]);
                        num += frac * longint'((i + 1) * WEIGHT_STEP * 16);
                        den += frac;
                    end
                    if (den == 0) begin
                        w.st = ST_NOLINE;
                    end else begin
                        q = num / den;
                        if (q > POS_MAX) q = POS_MAX;
                        w.pos = q[POS_W-1:0];
                        w.st  = ST_OK;
                    end
                end
            end
            pending_words.push_back(w);
        endfunction

        function void check_word(logic [POS_W-1:0] pos, logic [1:0] st);
            t_centroid_word w;
            words_out++;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word pos=%0d status=%0d", pos, st));
                return;
            end
            w = pending_words.pop_front();
            status_seen[w.st]++;
            if (st !== w.st)
                report_mismatch($sformatf("status %0d, expected %0d", st, w.st));
            if (pos !== w.pos)
                report_mismatch($sformatf("position %0d, expected %0d", pos, w.pos));
        endfunction
    endclass

    localparam int N_RANDOM   = 680;
    localparam int STALL_CAP  = 5000;

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    logic             i_command;
    t_readings        cur_rd;
    logic             empty;
    logic             pop;
    logic [POS_W-1:0] o_position_q4;
    logic [1:0]       o_status;
    bit               quiet;
    int               idle_cycles;

    centroid_scoreboard sb;

    line_sensor_calibrated_centroid dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_command(i_command),
        .i_decay_0(cur_rd[0]), .i_decay_1(cur_rd[1]), .i_decay_2(cur_rd[2]),
        .i_decay_3(cur_rd[3]), .i_decay_4(cur_rd[4]), .i_decay_5(cur_rd[5]),
        .i_decay_6(cur_rd[6]), .i_decay_7(cur_rd[7]),
        .empty(empty), .pop(pop),
        .o_position_q4(o_position_q4), .o_status(o_status)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // result side: random pop, check on every accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) sb.check_word(o_position_q4, o_status);
            pop <= quiet || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_CAP) begin
            $display("timeout: no progress for %0d cycles", STALL_CAP);
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_word(t_cmd cmd, t_readings rd);
        int gap;
        i_command <= cmd;
        cur_rd    <= rd;
        push      <= 1'b1;
        @(posedge i_clk);
        while (!(push && !full)) @(posedge i_clk);
        sb.note_word(cmd, rd);
        if (!quiet && $urandom_range(99) < 8) begin
            push <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_readings fill(int v);
        t_readings rd;
        for (int i = 0; i < NUM_SENSORS; i++) rd[i] = v[READING_BITS-1:0];
        return rd;
    endfunction

    function automatic t_readings rand_readings(int lo, int hi);
        t_readings rd;
        for (int i = 0; i < NUM_SENSORS; i++)
            rd[i] = READING_BITS'($urandom_range(hi, lo));
        return rd;
    endfunction

    initial begin
        t_readings rd;
        int        pick;
        sb          = new();
        quiet       = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_command   = CMD_CALIBRATE;
        cur_rd      = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // uncalibrated, then one reading that sets both max and min
        send_word(CMD_POSITION, fill(0));
        send_word(CMD_CALIBRATE, fill(1000));
        send_word(CMD_POSITION, fill(1000));
        send_word(CMD_CALIBRATE, fill(3000));
        send_word(CMD_POSITION, fill(0));
        send_word(CMD_POSITION, fill(65535));
        send_word(CMD_POSITION, fill(2000));
        for (int k = 0; k < NUM_SENSORS; k += 7) begin
            rd = fill(0);
            rd[k] = 16'hFFFF;
            send_word(CMD_POSITION, rd);
        end
        rd = fill(1000);
        rd[3] = 1001;
        send_word(CMD_POSITION, rd);
        rd = fill(900);
        rd[5] = 16'hAAAA;
        rd[2] = 16'h5555;
        send_word(CMD_POSITION, rd);
        send_word(CMD_POSITION, rand_readings(0, 65535));

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 250 && n < 400);
            pick  = $urandom_range(99);
            if (pick < 8)
                send_word(CMD_CALIBRATE, rand_readings(600, 4500));
            else if (pick < 10)
                send_word(CMD_CALIBRATE, rand_readings(0, 65535));
            else if (pick < 65)
                send_word(CMD_POSITION, rand_readings(0, 5000));
            else if (pick < 80)
                send_word(CMD_POSITION, rand_readings(0, 65535));
            else if (pick < 90)
                send_word(CMD_POSITION, rand_readings(0, 700));
            else begin
                rd = fill(0);
                rd[$urandom_range(NUM_SENSORS - 1)] = READING_BITS'($urandom);
                send_word(CMD_POSITION, rd);
            end
        end
        push  <= 1'b0;
        quiet = 0;

        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d words in, %0d out", sb.words_in, sb.words_out);
        $display("status ok/cal/notcal/noline: %0d/%0d/%0d/%0d", sb.status_seen[0],
                 sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        if (sb.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
